@@ hw/rtl/mi3_pkg.sv @@
// shared constants and control types for the 3x3 matrix inverse
// no dependencies
package mi3_pkg;

  localparam int QW       = 32;
  localparam int IN_FRAC  = 12;
  localparam int OUT_FRAC = 16;
  localparam int GUARD    = QW - IN_FRAC - OUT_FRAC;
  localparam int LANES    = 9;

  localparam logic [QW-1:0] POS_LIM = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIM = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic singular;
  } ctl_t;

  typedef struct packed {
    logic neg;
    logic ovf;
  } lane_t;

endpackage

@@ hw/rtl/mi3_front.sv @@
// front end: products, cofactors, determinant, magnitudes and divider setup
// depends on mi3_pkg
module mi3_front
  import mi3_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              valid,
  input  logic [LANES-1:0][W-1:0]           m,
  output ctl_t                              ctl,
  output logic [3*W+2:0]                    dmag,
  output lane_t [LANES-1:0]                 flags,
  output logic [LANES-1:0][3*W+2:0]         rem,
  output logic [LANES-1:0][QW-1:0]          quo
);

  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int TW = 3 * W + 1;
  localparam int DW = 3 * W + 3;

  logic [5:0]                  v;
  logic                        sg;

  logic [LANES-1:0][PW-1:0]    pa;
  logic [LANES-1:0][PW-1:0]    pb;
  logic [2:0][W-1:0]           row0_1;
  logic [2:0][W-1:0]           row0_2;
  logic [LANES-1:0][CW-1:0]    cof2;
  logic [LANES-1:0][CW-1:0]    cof3;
  logic [2:0][TW-1:0]          t3;
  logic [LANES-1:0][CW-1:0]    cof4;
  logic [DW-1:0]               det4;
  logic [LANES-1:0][CW-1:0]    cmag5;
  logic [LANES-1:0]            cneg5;
  logic [DW-1:0]               dmag5;
  logic                        dneg5;
  logic                        zero5;

  // lane k = r*3 + c holds cofactor (c, r)
  for (genvar k = 0; k < LANES; k++) begin : g_prod
    localparam int I  = k % 3;
    localparam int J  = k / 3;
    localparam int A0 = ((I + 1) % 3) * 3 + (J + 1) % 3;
    localparam int A1 = ((I + 2) % 3) * 3 + (J + 2) % 3;
    localparam int B0 = ((I + 2) % 3) * 3 + (J + 1) % 3;
    localparam int B1 = ((I + 1) % 3) * 3 + (J + 2) % 3;
    logic signed [PW-1:0] a_prod;
    logic signed [PW-1:0] b_prod;
    assign a_prod = $signed(m[A0]) * $signed(m[A1]);
    assign b_prod = $signed(m[B0]) * $signed(m[B1]);

    always_ff @(posedge clk) begin
      if (en) begin
        pa[k]   <= a_prod;
        pb[k]   <= b_prod;
        cof2[k] <= CW'($signed(pa[k])) - CW'($signed(pb[k]));
        cof3[k] <= cof2[k];
        cof4[k] <= cof3[k];
        cneg5[k] <= cof4[k][CW-1];
        cmag5[k] <= cof4[k][CW-1] ? CW'(-$signed(cof4[k])) : cof4[k];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_det
    logic signed [TW-1:0] t_prod;
    assign t_prod = $signed(row0_2[j]) * $signed(cof2[j*3]);
    always_ff @(posedge clk) begin
      if (en) begin
        row0_1[j] <= m[j];
        row0_2[j] <= row0_1[j];
        t3[j]     <= t_prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det4  <= DW'($signed(t3[0])) + DW'($signed(t3[1])) + DW'($signed(t3[2]));
      dneg5 <= det4[DW-1];
      zero5 <= (det4 == '0);
      dmag5 <= det4[DW-1] ? DW'(-$signed(det4)) : det4;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_init
    always_ff @(posedge clk) begin
      if (en) begin
        flags[k].neg <= cneg5[k] ^ dneg5;
        flags[k].ovf <= {{(DW+GUARD-CW){1'b0}}, cmag5[k]} >= {dmag5, {GUARD{1'b0}}};
        rem[k]       <= {{(DW-CW+GUARD){1'b0}}, cmag5[k][CW-1:GUARD]};
        quo[k]       <= {cmag5[k][GUARD-1:0], {(QW-GUARD){1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg   <= zero5;
      dmag <= dmag5;
    end
  end

  assign ctl.valid    = v[5];
  assign ctl.singular = sg;

endmodule

@@ hw/rtl/mi3_div_stage.sv @@
// one restoring division step for all nine lanes, registered
// depends on mi3_pkg
module mi3_div_stage
  import mi3_pkg::*;
#(
  parameter int DW = 51
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  ctl_t                       ctl,
  input  logic [DW-1:0]              dmag,
  input  lane_t [LANES-1:0]          flags,
  input  logic [LANES-1:0][DW-1:0]   rem,
  input  logic [LANES-1:0][QW-1:0]   quo,
  output ctl_t                       ctl_q,
  output logic [DW-1:0]              dmag_q,
  output lane_t [LANES-1:0]          flags_q,
  output logic [LANES-1:0][DW-1:0]   rem_q,
  output logic [LANES-1:0][QW-1:0]   quo_q
);

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;
    assign trial = {rem[k], quo[k][QW-1]};
    assign ge    = trial >= {1'b0, dmag};
    assign diff  = trial - {1'b0, dmag};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]   <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_q[k]   <= {quo[k][QW-2:0], ge};
        flags_q[k] <= flags[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q.valid <= 1'b0;
    end else if (en) begin
      ctl_q.valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_q.singular <= ctl.singular;
      dmag_q         <= dmag;
    end
  end

endmodule

@@ hw/rtl/matrix_inverse_3x3.sv @@
// 3x3 matrix inverse by adjugate, Q4.12 in, saturated Q16.16 out
// depends on mi3_pkg, mi3_front, mi3_div_stage
//
// channel  direction  handshake              word
// mat      in         mat_valid / mat_stall  m00 .. m22
// inv      out        inv_valid / inv_stall  inv00 .. inv22, singular
//
// one matrix per cycle while the output is not stalled; 6 front stages, 32 divide steps, output
// the 32-step restoring divider sets the depth, one quotient bit per stage
// rst clears the valid bits of every stage
// a stalled output word freezes the whole pipeline and raises mat_stall
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         mat_valid,
  output logic                         mat_stall,
  input  logic signed [ELEM_WIDTH-1:0] m00,
  input  logic signed [ELEM_WIDTH-1:0] m01,
  input  logic signed [ELEM_WIDTH-1:0] m02,
  input  logic signed [ELEM_WIDTH-1:0] m10,
  input  logic signed [ELEM_WIDTH-1:0] m11,
  input  logic signed [ELEM_WIDTH-1:0] m12,
  input  logic signed [ELEM_WIDTH-1:0] m20,
  input  logic signed [ELEM_WIDTH-1:0] m21,
  input  logic signed [ELEM_WIDTH-1:0] m22,
  output logic                         inv_valid,
  input  logic                         inv_stall,
  output logic signed [QW-1:0]         inv00,
  output logic signed [QW-1:0]         inv01,
  output logic signed [QW-1:0]         inv02,
  output logic signed [QW-1:0]         inv10,
  output logic signed [QW-1:0]         inv11,
  output logic signed [QW-1:0]         inv12,
  output logic signed [QW-1:0]         inv20,
  output logic signed [QW-1:0]         inv21,
  output logic signed [QW-1:0]         inv22,
  output logic                         singular
);

  localparam int DW = 3 * ELEM_WIDTH + 3;

  logic                               en;
  logic [LANES-1:0][ELEM_WIDTH-1:0]   m;
  ctl_t  [QW:0]                       ctl_s;
  logic  [QW:0][DW-1:0]               dmag_s;
  lane_t [QW:0][LANES-1:0]            flags_s;
  logic  [QW:0][LANES-1:0][DW-1:0]    rem_s;
  logic  [QW:0][LANES-1:0][QW-1:0]    quo_s;
  logic  [LANES-1:0][QW-1:0]          res;
  logic  [LANES-1:0][QW-1:0]          inv;

  assign en        = !(inv_valid && inv_stall);
  assign mat_stall = inv_valid && inv_stall;

  assign m = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

  mi3_front #(.W(ELEM_WIDTH)) u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .valid (mat_valid),
    .m     (m),
    .ctl   (ctl_s[0]),
    .dmag  (dmag_s[0]),
    .flags (flags_s[0]),
    .rem   (rem_s[0]),
    .quo   (quo_s[0])
  );

  for (genvar s = 0; s < QW; s++) begin : g_div
    mi3_div_stage #(.DW(DW)) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl     (ctl_s[s]),
      .dmag    (dmag_s[s]),
      .flags   (flags_s[s]),
      .rem     (rem_s[s]),
      .quo     (quo_s[s]),
      .ctl_q   (ctl_s[s+1]),
      .dmag_q  (dmag_s[s+1]),
      .flags_q (flags_s[s+1]),
      .rem_q   (rem_s[s+1]),
      .quo_q   (quo_s[s+1])
    );
  end

  for (genvar k = 0; k < LANES; k++) begin : g_sat
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    assign lim = flags_s[QW][k].neg ? NEG_LIM : POS_LIM;
    assign mag = (flags_s[QW][k].ovf || quo_s[QW][k] > lim) ? lim : quo_s[QW][k];
    assign res[k] = ctl_s[QW].singular ? '0 : (flags_s[QW][k].neg ? -mag : mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_valid <= 1'b0;
    end else if (en) begin
      inv_valid <= ctl_s[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv      <= res;
      singular <= ctl_s[QW].singular;
    end
  end

  assign inv00 = inv[0];
  assign inv01 = inv[1];
  assign inv02 = inv[2];
  assign inv10 = inv[3];
  assign inv11 = inv[4];
  assign inv12 = inv[5];
  assign inv20 = inv[6];
  assign inv21 = inv[7];
  assign inv22 = inv[8];

endmodule

@@ hw/rtl/mi3_checker.sv @@
// port-level checks for matrix_inverse_3x3, bound to the top level
// depends on mi3_pkg
module mi3_checker
  import mi3_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          mat_stall,
  input logic          inv_valid,
  input logic          inv_stall,
  input logic [QW-1:0] inv00,
  input logic [QW-1:0] inv01,
  input logic [QW-1:0] inv02,
  input logic [QW-1:0] inv10,
  input logic [QW-1:0] inv11,
  input logic [QW-1:0] inv12,
  input logic [QW-1:0] inv20,
  input logic [QW-1:0] inv21,
  input logic [QW-1:0] inv22,
  input logic          singular
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv_stall |=> inv_valid)
    else $error("output word dropped under stall");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    inv_valid && singular |-> inv00 == '0 && inv01 == '0 && inv02 == '0 &&
      inv10 == '0 && inv11 == '0 && inv12 == '0 && inv20 == '0 &&
      inv21 == '0 && inv22 == '0)
    else $error("singular word with nonzero elements");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    mat_stall |-> inv_valid && inv_stall)
    else $error("input stalled without output backpressure");

  a_reset: assert property (@(posedge clk)
    rst |=> !inv_valid)
    else $error("output valid after reset");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk       (clk),
  .rst       (rst),
  .mat_stall (mat_stall),
  .inv_valid (inv_valid),
  .inv_stall (inv_stall),
  .inv00     (inv00),
  .inv01     (inv01),
  .inv02     (inv02),
  .inv10     (inv10),
  .inv11     (inv11),
  .inv12     (inv12),
  .inv20     (inv20),
  .inv21     (inv21),
  .inv22     (inv22),
  .singular  (singular)
);
